>>> design/srg_pkg.sv
// Shared types and constants for the stepper ramp generator with homing.
// Holds the item kinds, register indexes, sequencer states and the
// request/response structs of the shared divider. No dependencies.
package srg_pkg;

   // Width of the shared divider and multiplier operands.
   localparam int DIV_W = 64;
   localparam int MUL_W = 32;

   // Largest magnitude of the ramp step count.
   localparam logic [31:0] N_LIMIT = 32'h7FFF_FFFF;

   // First interval for an acceleration of one step per second squared,
   // in millionths of a second per tick-second.
   localparam logic [31:0] FIRST_AT_ONE_PPM = 32'd956008;

   // Input transaction kinds.
   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_MOVE   = 2'd1,
      KIND_HOME   = 2'd2,
      KIND_SENSOR = 2'd3
   } kind_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_SENSOR_INVERTED   = 3'd0,
      CSR_HOMING_INCREMENT  = 3'd1,
      CSR_HOMING_MIN_IVL    = 3'd2,
      CSR_HOMING_FIRST_IVL  = 3'd3,
      CSR_HOMING_ACCEL      = 3'd4
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAX,
      ST_TGT,
      ST_ACC_CHK,
      ST_ACC_MUL,
      ST_ACC_GO,
      ST_ACC_WAIT,
      ST_STEP,
      ST_C_STS,
      ST_C_VW,
      ST_C_SQ,
      ST_C_SW,
      ST_C_DEC,
      ST_C_QW,
      ST_OUT
   } seq_state_type;

   // Divider request and response.
   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> design/srg_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on srg_pkg for the operand width and the request structs.
module srg_divider (
   input  logic                clock,
   input  logic                reset,
   input  srg_pkg::div_req_type req,
   output srg_pkg::div_rsp_type rsp
);

   localparam int W  = srg_pkg::DIV_W;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;
   logic          ge;

   // One restoring step on the partial remainder.
   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? W'(shifted - {1'b0, dvs_ff}) : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> design/srg_multiplier.sv
// Shared unsigned multiplier with a registered product.
// Depends on srg_pkg for the operand width.
module srg_multiplier (
   input  logic                           clock,
   input  logic [srg_pkg::MUL_W-1:0]      op_a,
   input  logic [srg_pkg::MUL_W-1:0]      op_b,
   output logic [2*srg_pkg::MUL_W-1:0]    prod
);

   logic [2*srg_pkg::MUL_W-1:0] prod_ff, prod_in;

   // Product of the current operands, taken into the product register.
   assign prod_in = {{srg_pkg::MUL_W{1'b0}}, op_a} * {{srg_pkg::MUL_W{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> design/stepper_ramp_generator_with_homing.sv
// Top level of the stepper ramp generator with homing: sequencer, state and ports.
// Depends on srg_pkg, srg_divider and srg_multiplier.
//
//   Channel | Direction | Handshake           | Contents
//   req     | in        | req_valid/req_stall | kind, target, intervals, accel, sensor
//   rsp     | out       | rsp_valid/rsp_stall | step pulse, direction, position, flags
//   csr     | in        | csr_write           | index and data of a config register
//
// A home start or a sensor sample goes from idle straight to the output state; a plain
// tick passes through the step state. Each ramp update runs up to three passes of the
// shared 64-bit serial divider, and an item runs up to four updates, plus a multiply
// and a divider pass for a change of acceleration.
// Reset is synchronous and active high. req_stall is high while an item is in
// work; the result waits in an output register until rsp_stall is low.
module stepper_ramp_generator_with_homing #(
   parameter int FRACTION_BITS    = 8,
   parameter int TICKS_PER_SECOND = 1000000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_target,
   input  logic [23:0] req_min_interval,
   input  logic [23:0] req_first_interval,
   input  logic [19:0] req_accel,
   input  logic        req_sensor_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_step_pulse,
   output logic        rsp_direction,
   output logic [31:0] rsp_position,
   output logic        rsp_running,
   output logic        rsp_homing,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int IW = 24 + FRACTION_BITS;
   localparam logic [63:0] NUM_C  = 64'(TICKS_PER_SECOND) << FRACTION_BITS;
   localparam logic [63:0] CAP64  = (64'd1 << IW) - 64'd1;
   localparam logic [IW-1:0] CAP  = IW'(CAP64);
   localparam logic [63:0] C0_RAW =
      (NUM_C * 64'(srg_pkg::FIRST_AT_ONE_PPM) + 64'd500000) / 64'd1000000;
   localparam logic [IW-1:0] FIRST0 = (C0_RAW > CAP64) ? CAP : IW'(C0_RAW);
   localparam logic [IW-1:0] MIN0   = (NUM_C > CAP64) ? CAP : IW'(NUM_C);

   // Microseconds to fixed point; zero counts as one.
   function automatic logic [IW-1:0] to_fx(input logic [23:0] us);
      logic [23:0] u;
      u = (us == 24'd0) ? 24'd1 : us;
      return IW'(u) << FRACTION_BITS;
   endfunction

   // Sequencer.
   srg_pkg::seq_state_type state_ff, state_in, ret_ff, ret_in;
   logic is_home_ff, is_home_in, ld_n_ff, ld_n_in, pulse_ff, pulse_in;

   // Latched operands of the item.
   logic [31:0] op_target_ff, op_target_in;
   logic [23:0] op_min_ff, op_min_in, op_first_ff, op_first_in;
   logic [19:0] op_accel_ff, op_accel_in;

   // Motor state.
   logic [31:0]   cur_ff, cur_in, tgt_ff, tgt_in, n_ff, n_in, elap_ff, elap_in;
   logic [IW-1:0] ci_ff, ci_in, min_ff, min_in, first_ff, first_in;
   logic [23:0]   si_ff, si_in;
   logic [19:0]   accel_ff, accel_in;
   logic [31:0]   sts_ff, sts_in;
   logic          cw_ff, cw_in, homing_ff, homing_in, sensor_ff, sensor_in;

   // Configuration registers.
   logic        inv_ff;
   logic [16:0] hinc_ff;
   logic [23:0] hmin_ff, hfirst_ff;
   logic [19:0] haccel_ff;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in, rsp_pulse_ff, rsp_pulse_in;
   logic        rsp_dir_ff, rsp_dir_in, rsp_run_ff, rsp_run_in, rsp_home_ff, rsp_home_in;
   logic [31:0] rsp_pos_ff, rsp_pos_in;

   // Shared units.
   srg_pkg::div_req_type div_req;
   srg_pkg::div_rsp_type div_rsp;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;

   srg_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   srg_multiplier u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // Shared conditions.
   logic          req_acc, out_free, n_gt0, max_chg, tgt_chg, acc_chg, do_step, sts_skip;
   logic [IW-1:0] fx_op;
   logic [31:0]   elap_new, n_abs;
   srg_pkg::seq_state_type nxt_max, nxt_acc;

   assign req_acc  = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fx_op    = to_fx(op_min_ff);
   assign n_gt0    = !n_ff[31] && (n_ff != 32'd0);
   assign n_abs    = n_ff[31] ? (32'd0 - n_ff) : n_ff;
   assign max_chg  = fx_op != min_ff;
   assign tgt_chg  = op_target_ff != tgt_ff;
   assign acc_chg  = (op_accel_ff != 20'd0) && (op_accel_ff != accel_ff);
   assign elap_new = (&elap_ff) ? elap_ff : elap_ff + 32'd1;
   assign do_step  = (si_ff != 24'd0) && (elap_new >= {8'd0, si_ff});
   assign sts_skip = (si_ff == 24'd0) || (ci_ff == '0);
   assign nxt_max  = is_home_ff ? srg_pkg::ST_STEP : srg_pkg::ST_TGT;
   assign nxt_acc  = is_home_ff ? srg_pkg::ST_MAX : srg_pkg::ST_OUT;

   // Ramp decision: distance, direction rules and the new step count.
   logic [32:0] dist_full, dist_mag;
   logic        dist_pos, dist_neg, stop_c, n1_zero;
   logic [31:0] n_eff, n1, n1_abs;
   logic        ne_pos, ne_neg;
   logic [33:0] den;

   always_comb begin
      dist_full = {tgt_ff[31], tgt_ff} - {cur_ff[31], cur_ff};
      dist_neg  = dist_full[32];
      dist_pos  = !dist_full[32] && (dist_full != 33'd0);
      dist_mag  = dist_neg ? (33'd0 - dist_full) : dist_full;
      stop_c    = (dist_full == 33'd0) && (sts_ff <= 32'd1);
      n_eff     = ld_n_ff ? sts_ff : n_ff;
      ne_pos    = !n_eff[31] && (n_eff != 32'd0);
      ne_neg    = n_eff[31];
      n1        = n_eff;
      if (dist_pos) begin
         if (ne_pos) begin
            if (({1'b0, sts_ff} >= dist_mag) || !cw_ff) n1 = 32'd0 - sts_ff;
         end else if (ne_neg) begin
            if (({1'b0, sts_ff} < dist_mag) && cw_ff) n1 = 32'd0 - n_eff;
         end
      end else if (dist_neg) begin
         if (ne_pos) begin
            if (({1'b0, sts_ff} >= dist_mag) || cw_ff) n1 = 32'd0 - sts_ff;
         end else if (ne_neg) begin
            if (({1'b0, sts_ff} < dist_mag) && !cw_ff) n1 = 32'd0 - n_eff;
         end
      end
      n1_zero = n1 == 32'd0;
      n1_abs  = n1[31] ? (32'd0 - n1) : n1;
      den     = n1[31] ? ({n1_abs, 2'b00} - 34'd1) : ({n1_abs, 2'b00} + 34'd1);
   end

   // Interval update from the divider quotient.
   logic [IW:0]   cn_sum;
   logic [IW-1:0] cn_a, cn_b;
   logic [31:0]   n_next, acc_mag;

   always_comb begin
      cn_sum = {1'b0, ci_ff} + div_rsp.quotient[IW:0];
      if (!n_ff[31]) cn_a = ci_ff - div_rsp.quotient[IW-1:0];
      else           cn_a = cn_sum[IW] ? CAP : cn_sum[IW-1:0];
      cn_b    = (cn_a < min_ff) ? min_ff : cn_a;
      n_next  = (n_ff == srg_pkg::N_LIMIT) ? srg_pkg::N_LIMIT : n_ff + 32'd1;
      acc_mag = (div_rsp.quotient[63:31] != 33'd0) ? srg_pkg::N_LIMIT
                                                   : div_rsp.quotient[31:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srg_pkg::ST_IDLE: begin
            if (req_acc) begin
               unique case (srg_pkg::kind_type'(req_kind))
                  srg_pkg::KIND_MOVE: state_in = srg_pkg::ST_MAX;
                  srg_pkg::KIND_HOME,
                  srg_pkg::KIND_SENSOR: state_in = srg_pkg::ST_OUT;
                  default:
                     state_in = (homing_ff && !sensor_ff) ? srg_pkg::ST_TGT
                                                          : srg_pkg::ST_STEP;
               endcase
            end
         end
         srg_pkg::ST_MAX:     state_in = (max_chg && n_gt0) ? srg_pkg::ST_C_STS : nxt_max;
         srg_pkg::ST_TGT:     state_in = tgt_chg ? srg_pkg::ST_C_STS : srg_pkg::ST_ACC_CHK;
         srg_pkg::ST_ACC_CHK: state_in = acc_chg ? srg_pkg::ST_ACC_MUL : nxt_acc;
         srg_pkg::ST_ACC_MUL: state_in = srg_pkg::ST_ACC_GO;
         srg_pkg::ST_ACC_GO:  state_in = srg_pkg::ST_ACC_WAIT;
         srg_pkg::ST_ACC_WAIT: if (div_rsp.done) state_in = srg_pkg::ST_C_STS;
         srg_pkg::ST_STEP:    state_in = do_step ? srg_pkg::ST_C_STS : srg_pkg::ST_OUT;
         srg_pkg::ST_C_STS:   state_in = sts_skip ? srg_pkg::ST_C_DEC : srg_pkg::ST_C_VW;
         srg_pkg::ST_C_VW:    if (div_rsp.done) state_in = srg_pkg::ST_C_SQ;
         srg_pkg::ST_C_SQ:    state_in = srg_pkg::ST_C_SW;
         srg_pkg::ST_C_SW:    if (div_rsp.done) state_in = srg_pkg::ST_C_DEC;
         srg_pkg::ST_C_DEC:   state_in = (stop_c || n1_zero) ? ret_ff : srg_pkg::ST_C_QW;
         srg_pkg::ST_C_QW:    if (div_rsp.done) state_in = ret_ff;
         srg_pkg::ST_OUT:     if (out_free) state_in = srg_pkg::ST_IDLE;
         default:             state_in = srg_pkg::ST_IDLE;
      endcase
   end

   // Datapath and unit control for each state.
   always_comb begin
      ret_in       = ret_ff;
      is_home_in   = is_home_ff;
      ld_n_in      = ld_n_ff;
      pulse_in     = pulse_ff;
      op_target_in = op_target_ff;
      op_min_in    = op_min_ff;
      op_first_in  = op_first_ff;
      op_accel_in  = op_accel_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      n_in         = n_ff;
      elap_in      = elap_ff;
      ci_in        = ci_ff;
      min_in       = min_ff;
      first_in     = first_ff;
      si_in        = si_ff;
      accel_in     = accel_ff;
      sts_in       = sts_ff;
      cw_in        = cw_ff;
      homing_in    = homing_ff;
      sensor_in    = sensor_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pulse_in = rsp_pulse_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_home_in  = rsp_home_ff;
      div_req      = '0;
      mul_a        = div_rsp.quotient[31:0];
      mul_b        = div_rsp.quotient[31:0];
      unique case (state_ff)
         srg_pkg::ST_IDLE: begin
            if (req_acc) begin
               pulse_in   = 1'b0;
               ld_n_in    = 1'b0;
               is_home_in = req_kind == srg_pkg::KIND_TICK;
               unique case (srg_pkg::kind_type'(req_kind))
                  srg_pkg::KIND_MOVE: begin
                     op_target_in = req_target;
                     op_min_in    = req_min_interval;
                     op_first_in  = req_first_interval;
                     op_accel_in  = req_accel;
                  end
                  srg_pkg::KIND_HOME: homing_in = 1'b1;
                  srg_pkg::KIND_SENSOR: begin
                     if (homing_ff) sensor_in = req_sensor_level ^ inv_ff;
                  end
                  default: begin
                     if (homing_ff && sensor_ff) begin
                        // Home found: zero the position and stop.
                        homing_in = 1'b0;
                        cur_in    = 32'd0;
                        tgt_in    = 32'd0;
                        n_in      = 32'd0;
                        si_in     = 24'd0;
                     end else begin
                        op_target_in = cur_ff + {{15{hinc_ff[16]}}, hinc_ff};
                        op_min_in    = hmin_ff;
                        op_first_in  = hfirst_ff;
                        op_accel_in  = haccel_ff;
                     end
                  end
               endcase
            end
         end
         srg_pkg::ST_MAX: begin
            if (max_chg) begin
               min_in = fx_op;
               if (n_gt0) begin
                  ld_n_in = 1'b1;
                  ret_in  = nxt_max;
               end
            end
         end
         srg_pkg::ST_TGT: begin
            if (tgt_chg) begin
               tgt_in = op_target_ff;
               ret_in = srg_pkg::ST_ACC_CHK;
            end
         end
         srg_pkg::ST_ACC_CHK: begin
            if (acc_chg) ret_in = nxt_acc;
         end
         srg_pkg::ST_ACC_MUL: begin
            mul_a = n_abs;
            mul_b = {12'd0, accel_ff};
         end
         srg_pkg::ST_ACC_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod;
            div_req.divisor  = 64'(op_accel_ff);
         end
         srg_pkg::ST_ACC_WAIT: begin
            if (div_rsp.done) begin
               n_in     = n_ff[31] ? (32'd0 - acc_mag) : acc_mag;
               first_in = to_fx(op_first_ff);
               accel_in = op_accel_ff;
            end
         end
         srg_pkg::ST_STEP: begin
            elap_in = elap_new;
            if (do_step) begin
               cur_in   = cw_ff ? cur_ff + 32'd1 : cur_ff - 32'd1;
               elap_in  = 32'd0;
               pulse_in = 1'b1;
               ret_in   = srg_pkg::ST_OUT;
            end
         end
         srg_pkg::ST_C_STS: begin
            // Speed from the interval, first pass of steps to stop.
            if (sts_skip) begin
               sts_in = 32'd0;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = NUM_C;
               div_req.divisor  = 64'(ci_ff);
            end
         end
         srg_pkg::ST_C_VW: ;
         srg_pkg::ST_C_SQ: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod;
            div_req.divisor  = 64'({accel_ff, 1'b0});
         end
         srg_pkg::ST_C_SW: begin
            if (div_rsp.done) begin
               sts_in = (div_rsp.quotient[63:31] != 33'd0) ? srg_pkg::N_LIMIT
                                                           : div_rsp.quotient[31:0];
            end
         end
         srg_pkg::ST_C_DEC: begin
            ld_n_in = 1'b0;
            if (stop_c) begin
               si_in = 24'd0;
               n_in  = 32'd0;
            end else if (n1_zero) begin
               ci_in = first_ff;
               si_in = first_ff[IW-1:FRACTION_BITS];
               cw_in = dist_pos;
               n_in  = 32'd1;
            end else begin
               n_in             = n1;
               div_req.start    = 1'b1;
               div_req.dividend = 64'({ci_ff, 1'b0});
               div_req.divisor  = 64'(den);
            end
         end
         srg_pkg::ST_C_QW: begin
            if (div_rsp.done) begin
               ci_in = cn_b;
               si_in = cn_b[IW-1:FRACTION_BITS];
               n_in  = n_next;
            end
         end
         srg_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pulse_in = pulse_ff;
               rsp_dir_in   = cw_ff;
               rsp_pos_in   = cur_ff;
               rsp_run_in   = (si_ff != 24'd0) || (tgt_ff != cur_ff);
               rsp_home_in  = homing_ff;
            end
         end
         default: ;
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff    <= 1'b0;
         hinc_ff   <= 17'd16;
         hmin_ff   <= 24'd1000;
         hfirst_ff <= 24'd20000;
         haccel_ff <= 20'd1000;
      end else if (csr_write) begin
         unique case (srg_pkg::csr_index_type'(csr_index))
            srg_pkg::CSR_SENSOR_INVERTED:  inv_ff    <= csr_data[0];
            srg_pkg::CSR_HOMING_INCREMENT: hinc_ff   <= csr_data[16:0];
            srg_pkg::CSR_HOMING_MIN_IVL:   hmin_ff   <= csr_data;
            srg_pkg::CSR_HOMING_FIRST_IVL: hfirst_ff <= csr_data;
            srg_pkg::CSR_HOMING_ACCEL:     haccel_ff <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srg_pkg::ST_IDLE;
         ret_ff       <= srg_pkg::ST_IDLE;
         is_home_ff   <= 1'b0;
         ld_n_ff      <= 1'b0;
         pulse_ff     <= 1'b0;
         cur_ff       <= 32'd0;
         tgt_ff       <= 32'd0;
         n_ff         <= 32'd0;
         elap_ff      <= 32'd0;
         ci_ff        <= '0;
         min_ff       <= MIN0;
         first_ff     <= FIRST0;
         si_ff        <= 24'd0;
         accel_ff     <= 20'd1;
         sts_ff       <= 32'd0;
         cw_ff        <= 1'b0;
         homing_ff    <= 1'b0;
         sensor_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         is_home_ff   <= is_home_in;
         ld_n_ff      <= ld_n_in;
         pulse_ff     <= pulse_in;
         cur_ff       <= cur_in;
         tgt_ff       <= tgt_in;
         n_ff         <= n_in;
         elap_ff      <= elap_in;
         ci_ff        <= ci_in;
         min_ff       <= min_in;
         first_ff     <= first_in;
         si_ff        <= si_in;
         accel_ff     <= accel_in;
         sts_ff       <= sts_in;
         cw_ff        <= cw_in;
         homing_ff    <= homing_in;
         sensor_ff    <= sensor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_target_ff <= op_target_in;
      op_min_ff    <= op_min_in;
      op_first_ff  <= op_first_in;
      op_accel_ff  <= op_accel_in;
      rsp_pulse_ff <= rsp_pulse_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_run_ff   <= rsp_run_in;
      rsp_home_ff  <= rsp_home_in;
   end

   // Ports.
   assign req_stall      = state_ff != srg_pkg::ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_pulse = rsp_pulse_ff;
   assign rsp_direction  = rsp_dir_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_running    = rsp_run_ff;
   assign rsp_homing     = rsp_home_ff;

   // A divider result only arrives while the sequencer waits for one.
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == srg_pkg::ST_ACC_WAIT || state_ff == srg_pkg::ST_C_VW ||
                        state_ff == srg_pkg::ST_C_SW || state_ff == srg_pkg::ST_C_QW))
      else $error("divider finished outside a wait state");

   // The ramp step count never reaches the most negative code.
   a_n_range: assert property (@(posedge clock) disable iff (reset)
      n_ff != 32'h8000_0000)
      else $error("ramp step count out of range");

   // A pending load of the step count is consumed before the item ends.
   a_ldn_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == srg_pkg::ST_IDLE |-> !ld_n_ff)
      else $error("step count load left pending");

   // A step taken on a tick is reported with the result.
   a_step_pulse: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srg_pkg::ST_STEP && do_step) |=> pulse_ff)
      else $error("step not recorded");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the stepper ramp generator with homing.
// Depends on srg_pkg and the stepper_ramp_generator_with_homing top level.
module tb_top;

   localparam int FRAC = 8;
   localparam int TPS = 1000000;
   localparam longint unsigned IVL_CAP = (64'd1 << (24 + FRAC)) - 1;
   localparam longint NMAX = 64'sd2147483647;
   localparam int CYCLE_LIMIT = 10000000;

   // One input transaction.
   typedef struct {
      srg_pkg::kind_type kind;
      logic [31:0] target;
      logic [23:0] min_ivl;
      logic [23:0] first_ivl;
      logic [19:0] accel;
      logic        level;
   } cmd_type;

   // One result transaction.
   typedef struct {
      logic        pulse;
      logic        dir;
      logic [31:0] pos;
      logic        run;
      logic        hom;
   } status_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_kind = 0;
   logic [31:0] req_target = 0;
   logic [23:0] req_min_interval = 0;
   logic [23:0] req_first_interval = 0;
   logic [19:0] req_accel = 0;
   logic        req_sensor_level = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_step_pulse;
   logic        rsp_direction;
   logic [31:0] rsp_position;
   logic        rsp_running;
   logic        rsp_homing;
   logic        csr_write = 0;
   logic [2:0]  csr_index = 0;
   logic [23:0] csr_data = 0;

   stepper_ramp_generator_with_homing dut (.*);

   always #10 clock = ~clock;

   // Predictor state: configuration copy.
   logic        p_inv;
   logic [16:0] p_hinc;
   logic [23:0] p_hmin, p_hfirst;
   logic [19:0] p_hacc;
   // Predictor state: motor.
   logic [31:0]     m_pos, m_tgt;
   longint          m_n;
   longint unsigned m_cn;
   logic [31:0]     m_ivl, m_elapsed;
   logic            m_cw, m_homing, m_sensor;
   longint unsigned m_acc, m_min, m_first;

   cmd_type    pending_cmds[$];
   status_type expected_status[$];
   int      sender_idle_pct = 0, receiver_stall_pct = 0;
   bit      hold_rsp = 0;
   bit      failed = 0;
   int      cycle_count = 0;

   // Set at each rising edge: the offered transaction was not yet taken.
   logic req_stall_seen = 0;

   function automatic longint unsigned us_fixed(longint unsigned us);
      longint unsigned v;
      if (us == 0) us = 1;
      v = us << FRAC;
      return (v > IVL_CAP) ? IVL_CAP : v;
   endfunction

   function automatic longint clamp_count(longint x);
      if (x > NMAX) return NMAX;
      if (x < -NMAX) return -NMAX;
      return x;
   endfunction

   function automatic longint stop_distance();
      longint unsigned v, s;
      if (m_ivl == 0 || m_cn == 0) return 0;
      v = (longint'(TPS) << FRAC) / m_cn;
      s = (v * v) / (2 * ((m_acc != 0) ? m_acc : 1));
      return (s > NMAX) ? NMAX : longint'(s);
   endfunction

   // Next interval from the ramp equations.
   function automatic void update_speed();
      longint gap, sts, n, den;
      longint unsigned cn;
      gap = longint'($signed(m_tgt)) - longint'($signed(m_pos));
      sts = stop_distance();
      n = m_n;
      cn = m_cn;
      if (gap == 0 && sts <= 1) begin
         m_ivl = 0;
         m_n = 0;
         return;
      end
      if (gap > 0) begin
         if (n > 0) begin
            if (sts >= gap || !m_cw) n = -sts;
         end else if (n < 0) begin
            if (sts < gap && m_cw) n = -n;
         end
      end else if (gap < 0) begin
         if (n > 0) begin
            if (sts >= -gap || m_cw) n = -sts;
         end else if (n < 0) begin
            if (sts < -gap && !m_cw) n = -n;
         end
      end
      if (n == 0) begin
         cn = m_first;
         m_cw = gap > 0;
      end else begin
         den = 4 * n + 1;
         if (den > 0) cn -= (2 * cn) / longint'(den);
         else begin
            cn += (2 * cn) / longint'(-den);
            if (cn > IVL_CAP) cn = IVL_CAP;
         end
         if (cn < m_min) cn = m_min;
      end
      m_n = clamp_count(n + 1);
      m_cn = cn;
      m_ivl = cn[FRAC +: 32];
   endfunction

   function automatic void apply_max(logic [23:0] us);
      longint unsigned fx;
      fx = us_fixed(us);
      if (fx != m_min) begin
         m_min = fx;
         if (m_n > 0) begin
            m_n = stop_distance();
            update_speed();
         end
      end
   endfunction

   function automatic void apply_accel(logic [19:0] a, logic [23:0] first_us);
      if (a == 0 || a == m_acc) return;
      m_n = clamp_count((m_n * longint'(m_acc)) / longint'(a));
      m_first = us_fixed(first_us);
      m_acc = a;
      update_speed();
   endfunction

   function automatic void apply_target(logic [31:0] t);
      if (t != m_tgt) begin
         m_tgt = t;
         update_speed();
      end
   endfunction

   function automatic void motor_reset();
      longint unsigned c0;
      p_inv = 0; p_hinc = 16; p_hmin = 1000; p_hfirst = 20000; p_hacc = 1000;
      m_pos = 0; m_tgt = 0; m_n = 0; m_cn = 0; m_ivl = 0; m_elapsed = 0;
      m_cw = 0; m_homing = 0; m_sensor = 0; m_acc = 1;
      m_min = us_fixed(TPS);
      c0 = ((longint'(TPS) << FRAC) * 956008 + 500000) / 1000000;
      m_first = (c0 > IVL_CAP) ? IVL_CAP : c0;
   endfunction

   // Works out the status that one transaction produces.
   function automatic status_type predict_status(cmd_type c);
      status_type s;
      logic pulse;
      pulse = 0;
      case (c.kind)
         srg_pkg::KIND_MOVE: begin
            apply_max(c.min_ivl);
            apply_target(c.target);
            if (c.accel != 0) apply_accel(c.accel, c.first_ivl);
         end
         srg_pkg::KIND_HOME: m_homing = 1;
         srg_pkg::KIND_SENSOR: begin
            if (m_homing) m_sensor = c.level ^ p_inv;
         end
         default: begin
            if (m_homing) begin
               if (m_sensor) begin
                  m_homing = 0; m_pos = 0; m_tgt = 0; m_n = 0; m_ivl = 0;
               end else begin
                  apply_target(m_pos + {{15{p_hinc[16]}}, p_hinc});
                  apply_accel(p_hacc, p_hfirst);
                  apply_max(p_hmin);
               end
            end
            if (m_elapsed != 32'hFFFF_FFFF) m_elapsed++;
            if (m_ivl != 0 && m_elapsed >= m_ivl) begin
               m_pos = m_cw ? m_pos + 1 : m_pos - 1;
               m_elapsed = 0;
               pulse = 1;
               update_speed();
            end
         end
      endcase
      s.pulse = pulse;
      s.dir = m_cw;
      s.pos = m_pos;
      s.run = (m_ivl != 0) || (m_tgt != m_pos);
      s.hom = m_homing;
      return s;
   endfunction

   // Driver: offers queued transactions at the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall_seen) begin
            // hold until accepted
         end else if (pending_cmds.size() != 0 &&
                      $urandom_range(99) >= sender_idle_pct) begin
            cmd_type c;
            c = pending_cmds.pop_front();
            req_kind <= c.kind;
            req_target <= c.target;
            req_min_interval <= c.min_ivl;
            req_first_interval <= c.first_ivl;
            req_accel <= c.accel;
            req_sensor_level <= c.level;
            req_valid <= 1;
         end else begin
            req_valid <= 0;
         end
         rsp_stall <= hold_rsp || ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Monitor: predicts on accepted requests and checks accepted results.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset) begin
         req_stall_seen <= req_valid && req_stall;
         if (req_valid && !req_stall) begin
            cmd_type c;
            c.kind = srg_pkg::kind_type'(req_kind);
            c.target = req_target;
            c.min_ivl = req_min_interval;
            c.first_ivl = req_first_interval;
            c.accel = req_accel;
            c.level = req_sensor_level;
            expected_status.push_back(predict_status(c));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               $error("result with no expectation waiting");
               failed = 1;
            end else begin
               status_type e;
               e = expected_status.pop_front();
               if (rsp_step_pulse !== e.pulse) begin
                  $error("step_pulse: expected %0d, got %0d", e.pulse, rsp_step_pulse);
                  failed = 1;
               end
               if (rsp_direction !== e.dir) begin
                  $error("direction: expected %0d, got %0d", e.dir, rsp_direction);
                  failed = 1;
               end
               if (rsp_position !== e.pos) begin
                  $error("position: expected %0d, got %0d",
                         $signed(e.pos), $signed(rsp_position));
                  failed = 1;
               end
               if (rsp_running !== e.run) begin
                  $error("running: expected %0d, got %0d", e.run, rsp_running);
                  failed = 1;
               end
               if (rsp_homing !== e.hom) begin
                  $error("homing: expected %0d, got %0d", e.hom, rsp_homing);
                  failed = 1;
               end
            end
         end
      end
   end

   // Receiver hold-off for a long stretch, counted in its own process.
   task automatic long_holdoff(int cycles);
      @(negedge clock);
      hold_rsp = 1;
      repeat (cycles) @(posedge clock);
      hold_rsp = 0;
   endtask

   function automatic cmd_type make_cmd(srg_pkg::kind_type k, logic [31:0] t,
                                        logic [23:0] mn, logic [23:0] fi,
                                        logic [19:0] a, logic lv);
      cmd_type c;
      c.kind = k; c.target = t; c.min_ivl = mn; c.first_ivl = fi;
      c.accel = a; c.level = lv;
      return c;
   endfunction

   // A random move with mostly short distances and fast ramps.
   function automatic cmd_type random_move();
      logic [31:0] t;
      t = ($urandom_range(9) == 0) ? $urandom() :
          m_pos + 32'($signed($urandom_range(40)) - 20);
      return make_cmd(srg_pkg::KIND_MOVE, t,
                      ($urandom_range(7) == 0) ? 24'($urandom()) : 24'($urandom_range(12)),
                      ($urandom_range(7) == 0) ? 24'($urandom()) : 24'($urandom_range(40)),
                      ($urandom_range(5) == 0) ? 20'($urandom()) :
                                                 20'($urandom_range(200000)),
                      1'($urandom()));
   endfunction

   function automatic cmd_type random_item();
      int r;
      r = $urandom_range(99);
      if (r < 70) return make_cmd(srg_pkg::KIND_TICK, $urandom(), 24'($urandom()),
                                  24'($urandom()), 20'($urandom()), 1'($urandom()));
      if (r < 85) return random_move();
      if (r < 90) return make_cmd(srg_pkg::KIND_HOME, $urandom(), 24'($urandom()),
                                  24'($urandom()), 20'($urandom()), 1'($urandom()));
      return make_cmd(srg_pkg::KIND_SENSOR, $urandom(), 24'($urandom()), 24'($urandom()),
                      20'($urandom()), $urandom_range(9) < 2);
   endfunction

   task automatic write_reg(srg_pkg::csr_index_type idx, logic [23:0] val);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 0;
      case (idx)
         srg_pkg::CSR_SENSOR_INVERTED:  p_inv = val[0];
         srg_pkg::CSR_HOMING_INCREMENT: p_hinc = val[16:0];
         srg_pkg::CSR_HOMING_MIN_IVL:   p_hmin = val;
         srg_pkg::CSR_HOMING_FIRST_IVL: p_hfirst = val;
         default:                       p_hacc = val[19:0];
      endcase
   endtask

   task automatic drain();
      while (pending_cmds.size() != 0 || req_valid || expected_status.size() != 0)
         @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   task automatic run_phase(int count, int idle, int stall);
      sender_idle_pct = idle;
      receiver_stall_pct = stall;
      repeat (count) pending_cmds.push_back(random_item());
      drain();
   endtask

   initial begin
      motor_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part: field extremes, every kind and the homing corner cases.
      pending_cmds.push_back(make_cmd(srg_pkg::KIND_SENSOR, 0, 0, 0, 0, 1));
      pending_cmds.push_back(make_cmd(srg_pkg::KIND_MOVE, 32'h7FFF_FFFF, 0, 0, 20'hFFFFF, 0));
      pending_cmds.push_back(make_cmd(srg_pkg::KIND_TICK, 32'hFFFF_FFFF, 24'hFFFFFF,
                                      24'hFFFFFF, 20'hFFFFF, 1));
      pending_cmds.push_back(make_cmd(srg_pkg::KIND_MOVE, 32'h8000_0000, 24'hFFFFFF,
                                      24'hFFFFFF, 0, 1));
      pending_cmds.push_back(make_cmd(srg_pkg::KIND_MOVE, 5, 1, 1, 1, 0));
      repeat (4) pending_cmds.push_back(make_cmd(srg_pkg::KIND_TICK, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(srg_pkg::KIND_MOVE, 0, 2, 3, 0, 0));
      pending_cmds.push_back(make_cmd(srg_pkg::KIND_HOME, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(srg_pkg::KIND_MOVE, 100, 2, 3, 5, 0));
      repeat (3) pending_cmds.push_back(make_cmd(srg_pkg::KIND_TICK, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(srg_pkg::KIND_SENSOR, 0, 0, 0, 0, 1));
      pending_cmds.push_back(make_cmd(srg_pkg::KIND_TICK, 0, 0, 0, 0, 0));
      // A stale true sensor ends the next homing run on its first tick.
      pending_cmds.push_back(make_cmd(srg_pkg::KIND_SENSOR, 0, 0, 0, 0, 1));
      pending_cmds.push_back(make_cmd(srg_pkg::KIND_HOME, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(srg_pkg::KIND_TICK, 0, 0, 0, 0, 0));
      drain();

      // Small homing steps with fast intervals and an inverted sensor.
      write_reg(srg_pkg::CSR_SENSOR_INVERTED, 1);
      write_reg(srg_pkg::CSR_HOMING_INCREMENT, 24'h1FFFF);
      write_reg(srg_pkg::CSR_HOMING_MIN_IVL, 1);
      write_reg(srg_pkg::CSR_HOMING_FIRST_IVL, 2);
      write_reg(srg_pkg::CSR_HOMING_ACCEL, 20'hFFFFF);
      run_phase(240, 0, 0);

      // Extreme increments and slow homing ramps.
      write_reg(srg_pkg::CSR_SENSOR_INVERTED, 0);
      write_reg(srg_pkg::CSR_HOMING_INCREMENT, 24'h10000);
      write_reg(srg_pkg::CSR_HOMING_MIN_IVL, 24'hFFFFFF);
      write_reg(srg_pkg::CSR_HOMING_FIRST_IVL, 24'hFFFFFF);
      write_reg(srg_pkg::CSR_HOMING_ACCEL, 1);
      sender_idle_pct = 54;
      fork
         long_holdoff(3000);
      join_none
      run_phase(230, 54, 0);

      write_reg(srg_pkg::CSR_HOMING_INCREMENT, 24'h0FFFF);
      write_reg(srg_pkg::CSR_HOMING_MIN_IVL, 3);
      write_reg(srg_pkg::CSR_HOMING_FIRST_IVL, 10);
      write_reg(srg_pkg::CSR_HOMING_ACCEL, 3000);
      run_phase(230, 0, 54);

      write_reg(srg_pkg::CSR_SENSOR_INVERTED, 1);
      write_reg(srg_pkg::CSR_HOMING_INCREMENT, 24'h1FFFD);
      run_phase(230, 18, 18);

      if (!failed) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
